### rtl/assert_macros.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/sha512_pkg.sv
`default_nettype none

package sha512_pkg;

    typedef logic [63:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    typedef enum logic [1:0] {
        VAR_384     = 2'd0,
        VAR_512     = 2'd1,
        VAR_512_224 = 2'd2,
        VAR_512_256 = 2'd3
    } variant_t;

    // compression sequencer timing, in cycles of the step counter
    localparam int         CNT_W          = 7;
    localparam logic [6:0] CNT_LOAD_END   = 7'd8;   // working vars shift in at 1..8
    localparam logic [6:0] CNT_BUF_RD0    = 7'd8;   // buffer read for W[0]
    localparam logic [6:0] CNT_SCHED0     = 7'd9;   // schedule step for W[0]
    localparam logic [6:0] CNT_SCHED_BUF  = 7'd24;  // last step taking W from the buffer
    localparam logic [6:0] CNT_SCHED_END  = 7'd88;
    localparam logic [6:0] CNT_ROUND0     = 7'd10;
    localparam logic [6:0] CNT_ROUND_END  = 7'd89;
    localparam logic [6:0] CNT_FIN_RD0    = 7'd90;
    localparam logic [6:0] CNT_FIN_WR0    = 7'd91;
    localparam logic [6:0] CNT_DONE       = 7'd98;

    localparam word_t K_TABLE [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam word_t IV_TABLE [4][8] = '{
        '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
          64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
        '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
          64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
        '{64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
          64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1},
        '{64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
          64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2}
    };

    // index of the final digest word for each variant
    function automatic logic [2:0] last_idx(input variant_t v);
        logic [2:0] r;
        begin
            unique case (v)
                VAR_384:     r = 3'd5;
                VAR_512:     r = 3'd7;
                VAR_512_224: r = 3'd3;
                VAR_512_256: r = 3'd3;
            endcase
            return r;
        end
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
    endfunction

endpackage

`default_nettype wire

### rtl/sha512_family_hash_core.sv
// SHA-384/512/512-224/512-256 hash core, one 64-bit message word per request.
// A word that fills a block starts a compression. After a last word, once its
// compression ends (or once it is accepted), each digest word is read from the
// chain memory in ST_OUT_RD and registered in ST_OUT_WR, which waits on m_tready.
// Words are accepted only while idle; compression time is set by the 80-round
// loop plus the chain load and read-modify-write passes. Synchronous active-low reset.
`default_nettype none
`include "assert_macros.svh"

module sha512_family_hash_core
    import sha512_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // variant register: 0 SHA-384, 1 SHA-512, 2 SHA-512/224, 3 SHA-512/256
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,    // [63:0] message_word
    input  wire logic        s_tlast,    // last_word

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [63:0] digest_word
    output logic             m_tlast     // digest_last
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    variant_t         variant_reg;
    logic [3:0]       wc_reg;          // words buffered in the current block
    logic [CNT_W-1:0] cnt_reg;         // compression step counter
    logic             fresh_reg;       // chain memory reads as the variant's IV
    logic             pend_last_reg;   // block-completing word was also the last one
    logic [2:0]       out_idx_reg;     // digest word being sent
    logic             m_valid_reg;

    // payload registers
    word_t            m_data_reg;
    logic             m_last_reg;
    word_t            wv_reg  [8];     // working vars a..h
    word_t            win_reg [16];    // schedule window, [15] newest
    word_t            wk_reg;          // W[r] + K[r] for the next round

    // memories: block buffer and chaining hash, registered reads
    word_t            buf_mem   [16];
    word_t            buf_q_reg;
    word_t            chain_mem [8];
    word_t            chain_q_reg;

    // ------------------------------------------------------------------
    // Decoded controls
    // ------------------------------------------------------------------
    logic             s_fire;
    logic             out_free;
    logic             out_is_last;
    logic             load_en;         // shift chain data into working vars
    logic             sched_en;
    logic             round_en;
    logic             fin_en;          // chain[k] += a, then shift
    logic             out_load;
    logic [2:0]       chain_raddr;
    logic [CNT_W-1:0] fin_rd_off;
    logic [CNT_W-1:0] fin_wr_off;
    logic [CNT_W-1:0] buf_rd_off;
    logic [CNT_W-1:0] sched_idx;
    logic [3:0]       buf_raddr;
    logic [2:0]       fin_waddr;

    assign s_fire      = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign out_is_last = (out_idx_reg == last_idx(variant_reg));
    assign fin_rd_off  = cnt_reg - CNT_FIN_RD0;
    assign fin_wr_off  = cnt_reg - CNT_FIN_WR0;
    assign buf_rd_off  = cnt_reg - CNT_BUF_RD0;
    assign sched_idx   = cnt_reg - CNT_SCHED0;
    assign buf_raddr   = buf_rd_off[3:0];
    assign fin_waddr   = fin_wr_off[2:0];

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                priority if (s_fire && wc_reg == '1) begin
                    state_next = ST_COMP;
                end else if (s_fire && s_tlast) begin
                    state_next = ST_OUT_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMP: begin
                if (cnt_reg == CNT_DONE) begin
                    state_next = pend_last_reg ? ST_OUT_RD : ST_IDLE;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_WR;
            end
            ST_OUT_WR: begin
                if (out_load) begin
                    state_next = out_is_last ? ST_IDLE : ST_OUT_RD;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready    = 1'b0;
        load_en     = 1'b0;
        sched_en    = 1'b0;
        round_en    = 1'b0;
        fin_en      = 1'b0;
        out_load    = 1'b0;
        chain_raddr = out_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_COMP: begin
                load_en  = (cnt_reg >= 7'd1) && (cnt_reg <= CNT_LOAD_END);
                sched_en = (cnt_reg >= CNT_SCHED0) && (cnt_reg <= CNT_SCHED_END);
                round_en = (cnt_reg >= CNT_ROUND0) && (cnt_reg <= CNT_ROUND_END);
                fin_en   = (cnt_reg >= CNT_FIN_WR0) && (cnt_reg <= CNT_DONE);
                // chain reads: IV/chain load first, then read-modify-write pass
                chain_raddr = (cnt_reg < CNT_FIN_RD0) ? cnt_reg[2:0] : fin_rd_off[2:0];
            end
            ST_OUT_RD: begin
            end
            ST_OUT_WR: begin
                out_load = out_free;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            variant_reg   <= VAR_512;
            wc_reg        <= '0;
            cnt_reg       <= '0;
            fresh_reg     <= 1'b1;
            pend_last_reg <= 1'b0;
            out_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_COMP) ? cnt_reg + 7'd1 : '0;

            // variant write reloads the IV and drops any message in progress
            if (cfg_wr_en) begin
                variant_reg <= variant_t'(cfg_wr_data);
                fresh_reg   <= 1'b1;
                wc_reg      <= '0;
            end

            if (s_fire) begin
                wc_reg        <= wc_reg + 4'd1;
                pend_last_reg <= s_tlast;
            end

            if (state_reg == ST_COMP && cnt_reg == CNT_DONE) begin
                fresh_reg <= 1'b0;
            end

            if (out_load) begin
                if (out_is_last) begin
                    // restart: chain back to IV, partial block dropped
                    out_idx_reg <= '0;
                    fresh_reg   <= 1'b1;
                    wc_reg      <= '0;
                end else begin
                    out_idx_reg <= out_idx_reg + 3'd1;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            buf_mem[wc_reg] <= s_tdata;
        end
        buf_q_reg <= buf_mem[buf_raddr];
    end

    // fresh entries read as the IV; the RMW pass never reads the entry it writes
    always_ff @(posedge aclk) begin
        if (fin_en) begin
            chain_mem[fin_waddr] <= chain_q_reg + wv_reg[0];
        end
        chain_q_reg <= fresh_reg ? IV_TABLE[variant_reg][chain_raddr]
                                 : chain_mem[chain_raddr];
    end

    // ------------------------------------------------------------------
    // Message schedule, one word ahead of the rounds
    // ------------------------------------------------------------------
    word_t w_new;
    always_comb begin
        if (cnt_reg <= CNT_SCHED_BUF) begin
            w_new = buf_q_reg;
        end else begin
            w_new = small_sigma1(win_reg[14]) + win_reg[9]
                  + small_sigma0(win_reg[1]) + win_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (sched_en) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
            wk_reg      <= w_new + K_TABLE[sched_idx];
        end
    end

    // ------------------------------------------------------------------
    // Round datapath
    // ------------------------------------------------------------------
    word_t t1, t2, ch, maj;
    always_comb begin
        ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1  = wv_reg[7] + big_sigma1(wv_reg[4]) + ch + wk_reg;
        t2  = big_sigma0(wv_reg[0]) + maj;
    end

    always_ff @(posedge aclk) begin
        if (load_en || fin_en) begin
            for (int i = 0; i < 7; i++) begin
                wv_reg[i] <= wv_reg[i+1];
            end
            wv_reg[7] <= chain_q_reg;
        end else if (round_en) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= chain_q_reg;
            // SHA-512/224 keeps only the upper half of its fourth word
            if (variant_reg == VAR_512_224 && out_idx_reg == 3'd3) begin
                m_data_reg[31:0] <= '0;
            end
            m_last_reg <= out_is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_block_starts_comp, aclk, aresetn, s_fire && wc_reg == 4'hF, state_reg == ST_COMP)
    `ASSERT_IMPLY(a_cnt_bounded, aclk, aresetn, state_reg == ST_COMP, cnt_reg <= CNT_DONE)
    `ASSERT_NEXT(a_restart_after_digest, aclk, aresetn, out_load && out_is_last, fresh_reg && wc_reg == 4'd0)
    `ASSERT_IMPLY(a_out_idx_range, aclk, aresetn, state_reg == ST_OUT_WR, out_idx_reg <= last_idx(variant_reg))

endmodule

`default_nettype wire
